// ----- src/csx_pkg.sv -----
// shared widths, register indexes and fixed-point limits for the can signal extractor
`default_nettype none

package csx_pkg;

  // payload word and signal field sizes
  localparam int unsigned WordBits  = 64;
  localparam int unsigned MaxLen    = 32;
  localparam int unsigned IdBits    = 29;
  localparam int unsigned StampBits = 64;
  localparam int unsigned ValBits   = 48;

  // configuration port geometry
  localparam int unsigned CfgAddrBits = 3;
  localparam int unsigned CfgDataBits = 48;

  // stream packing
  localparam int unsigned InDataBits  = 160;
  localparam int unsigned OutDataBits = 144;

  // configuration register indexes
  typedef enum logic [CfgAddrBits-1:0] {
    REG_MATCH_ID      = 3'd0,
    REG_BIT_OFFSET    = 3'd1,
    REG_BIT_LENGTH    = 3'd2,
    REG_SIGNAL_FORMAT = 3'd3,
    REG_SLOPE         = 3'd4,
    REG_INTERCEPT     = 3'd5,
    REG_LOWER_LIMIT   = 3'd6,
    REG_UPPER_LIMIT   = 3'd7
  } cfg_reg_e;

  // signed q32.16 output range
  localparam logic signed [ValBits-1:0] Q48Max = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [ValBits-1:0] Q48Min = 48'sh8000_0000_0000;

  // product saturation bound, plus and minus 2^62
  localparam logic signed [64:0] ProdMax = 65'sh0_4000_0000_0000_0000;
  localparam logic signed [64:0] ProdMin = -65'sh0_4000_0000_0000_0000;

endpackage

`default_nettype wire

// ----- src/csx_extract.sv -----
// bit field extraction in intel or motorola order with optional sign extension
`default_nettype none

module csx_extract (
  input  logic [63:0]        payload_i,
  input  logic [5:0]         offset_i,
  input  logic [5:0]         length_i,
  input  logic [1:0]         format_i,
  output logic [31:0]        raw_o,
  output logic signed [32:0] value_o
);
  import csx_pkg::*;

  logic [5:0]   len;
  logic [32:0]  mask;
  logic [63:0]  swapped;
  logic [6:0]   end_bit;
  logic [7:0]   mot_shift;
  logic [127:0] wide;
  logic [63:0]  word;
  logic [4:0]   top_idx;
  logic         neg;

  // byte swap for motorola order
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      swapped[8*b +: 8] = payload_i[8*(7-b) +: 8];
    end
  end

  // field selection and sign handling
  always_comb begin
    len       = (length_i > 6'(MaxLen)) ? 6'(MaxLen) : length_i;
    mask      = (33'd1 << len) - 33'd1;
    end_bit   = {1'b0, offset_i} + {1'b0, len};
    // swapped word followed by zeros, so a field past bit 63 reads zeros low
    mot_shift = 8'd128 - {1'b0, end_bit};
    wide      = {swapped, 64'd0} >> mot_shift;
    word      = format_i[0] ? wide[63:0] : (payload_i >> offset_i);
    raw_o     = word[31:0] & mask[31:0];
    top_idx   = 5'(len - 6'd1);
    neg       = format_i[1] && (len != 6'd0) && raw_o[top_idx];
    value_o   = neg ? signed'({1'b0, raw_o} | ~mask) : signed'({1'b0, raw_o});
  end

endmodule

`default_nettype wire

// ----- src/can_signal_extract_scale.sv -----
// Extracts one signal from matching CAN frames and scales it to a clamped
// q32.16 value. Frames enter on the slave stream; a frame whose identifier and
// extended flag equal the configured match_id has a bit field of 0 to 32 bits
// pulled from its payload (intel or motorola order, optionally signed), scaled
// as raw*slope+intercept, saturated to 48 bits and clamped to the limits. A
// result transfer happens only when the raw field differs from the one of the
// previous matching frame. The block takes one frame per cycle while the output
// is not stalled; each frame passes through four register stages (input,
// extraction, multiply, add and clamp into the output register). The user must
// write configuration only while the block is idle; the block itself does not
// enforce it.
`default_nettype none

module can_signal_extract_scale (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // slave stream, tdata: frame_id, payload, arrival_time, zero fill
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [csx_pkg::InDataBits-1:0]     s_axis_tdata,
  // tuser: frame_extended
  input  logic                               s_axis_tuser,
  // master stream, tdata: stamp, physical_value, raw_field
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [csx_pkg::OutDataBits-1:0]    m_axis_tdata,
  // configuration write port
  input  logic                               cfg_we_i,
  input  logic [csx_pkg::CfgAddrBits-1:0]    cfg_addr_i,
  input  logic [csx_pkg::CfgDataBits-1:0]    cfg_wdata_i
);
  import csx_pkg::*;

  // configuration registers
  logic [29:0]               match_id_q;
  logic [5:0]                bit_offset_q;
  logic [5:0]                bit_length_q;
  logic [1:0]                signal_format_q;
  logic signed [31:0]        slope_q;
  logic signed [ValBits-1:0] intercept_q;
  logic signed [ValBits-1:0] lower_limit_q;
  logic signed [ValBits-1:0] upper_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_id_q      <= '0;
      bit_offset_q    <= '0;
      bit_length_q    <= 6'd8;
      signal_format_q <= '0;
      slope_q         <= 32'sd65536;
      intercept_q     <= '0;
      lower_limit_q   <= Q48Min;
      upper_limit_q   <= Q48Max;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_MATCH_ID:      match_id_q      <= cfg_wdata_i[29:0];
        REG_BIT_OFFSET:    bit_offset_q    <= cfg_wdata_i[5:0];
        REG_BIT_LENGTH:    bit_length_q    <= cfg_wdata_i[5:0];
        REG_SIGNAL_FORMAT: signal_format_q <= cfg_wdata_i[1:0];
        REG_SLOPE:         slope_q         <= signed'(cfg_wdata_i[31:0]);
        REG_INTERCEPT:     intercept_q     <= signed'(cfg_wdata_i[ValBits-1:0]);
        REG_LOWER_LIMIT:   lower_limit_q   <= signed'(cfg_wdata_i[ValBits-1:0]);
        REG_UPPER_LIMIT:   upper_limit_q   <= signed'(cfg_wdata_i[ValBits-1:0]);
        default: ;
      endcase
    end
  end

  // stage valids and per-stage ready chain
  logic s1_v_q, s2_v_q, s3_v_q, m_v_q;
  logic out_rdy, s3_rdy, s2_rdy, s1_rdy;

  assign out_rdy       = !m_v_q || m_axis_tready;
  assign s3_rdy        = !s3_v_q || out_rdy;
  assign s2_rdy        = !s2_v_q || s3_rdy;
  assign s1_rdy        = !s1_v_q || s2_rdy;
  assign s_axis_tready = s1_rdy;
  assign m_axis_tvalid = m_v_q;

  // stage 1: input register
  logic [IdBits-1:0]    s1_id_q;
  logic                 s1_ext_q;
  logic [WordBits-1:0]  s1_payload_q;
  logic [StampBits-1:0] s1_stamp_q;
  logic                 in_fire;

  assign in_fire = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_rdy) begin
      s1_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_id_q      <= s_axis_tdata[IdBits-1:0];
      s1_payload_q <= s_axis_tdata[IdBits +: WordBits];
      s1_stamp_q   <= s_axis_tdata[IdBits+WordBits +: StampBits];
      s1_ext_q     <= s_axis_tuser;
    end
  end

  // field extraction and change detection
  logic [31:0]        ext_raw;
  logic signed [32:0] ext_val;
  logic               s1_match, s1_adv, s1_changed;
  logic [31:0]        last_raw_q;

  csx_extract u_extract (
    .payload_i (s1_payload_q),
    .offset_i  (bit_offset_q),
    .length_i  (bit_length_q),
    .format_i  (signal_format_q),
    .raw_o     (ext_raw),
    .value_o   (ext_val)
  );

  assign s1_match   = (s1_id_q == match_id_q[IdBits-1:0]) && (s1_ext_q == match_id_q[29]);
  assign s1_adv     = s1_v_q && s2_rdy;
  assign s1_changed = ext_raw != last_raw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_raw_q <= '0;
    end else if (s1_adv && s1_match) begin
      last_raw_q <= ext_raw;
    end
  end

  // stage 2: extracted field
  logic [31:0]          s2_raw_q;
  logic signed [32:0]   s2_val_q;
  logic [StampBits-1:0] s2_stamp_q;
  logic                 s2_load;

  assign s2_load = s1_adv && s1_match && s1_changed;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s2_rdy) begin
      s2_v_q <= s2_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      s2_raw_q   <= ext_raw;
      s2_val_q   <= ext_val;
      s2_stamp_q <= s1_stamp_q;
    end
  end

  // stage 3: product raw times slope
  logic signed [64:0]   s3_prod_q;
  logic [31:0]          s3_raw_q;
  logic [StampBits-1:0] s3_stamp_q;
  logic                 s3_load;

  assign s3_load = s2_v_q && s3_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (s3_rdy) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_load) begin
      s3_prod_q  <= 65'(s2_val_q) * 65'(slope_q);
      s3_raw_q   <= s2_raw_q;
      s3_stamp_q <= s2_stamp_q;
    end
  end

  // offset, saturation and limit clamp
  logic signed [64:0]        prod_sat;
  logic signed [63:0]        sum;
  logic signed [ValBits-1:0] val_sat;
  logic signed [ValBits-1:0] phys_d;

  always_comb begin
    prod_sat = s3_prod_q;
    if (s3_prod_q > ProdMax) begin
      prod_sat = ProdMax;
    end
    if (s3_prod_q < ProdMin) begin
      prod_sat = ProdMin;
    end
    sum = 64'(prod_sat) + 64'(intercept_q);
    if (sum > 64'(Q48Max)) begin
      val_sat = Q48Max;
    end else if (sum < 64'(Q48Min)) begin
      val_sat = Q48Min;
    end else begin
      val_sat = sum[ValBits-1:0];
    end
    phys_d = val_sat;
    if (phys_d < lower_limit_q) begin
      phys_d = lower_limit_q;
    end
    if (phys_d > upper_limit_q) begin
      phys_d = upper_limit_q;
    end
  end

  // output register
  logic [StampBits-1:0]      m_stamp_q;
  logic signed [ValBits-1:0] m_phys_q;
  logic [31:0]               m_raw_q;
  logic                      m_load;

  assign m_load = s3_v_q && out_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= 1'b0;
    end else if (out_rdy) begin
      m_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (m_load) begin
      m_stamp_q <= s3_stamp_q;
      m_phys_q  <= phys_d;
      m_raw_q   <= s3_raw_q;
    end
  end

  assign m_axis_tdata = {m_raw_q, m_phys_q, m_stamp_q};

  // stored raw value moves only on a matching frame leaving stage 1
  a_last_raw_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (last_raw_q != $past(last_raw_q)) |-> $past(s1_adv && s1_match))
    else $error("stored raw value changed without a matching frame");

  // a held stage keeps its item
  a_s2_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_v_q && !s3_rdy) |=> s2_v_q)
    else $error("stage 2 item dropped while stalled");

  // an empty pipeline always takes a frame
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!s1_v_q && !s2_v_q && !s3_v_q && !m_v_q) |-> s_axis_tready)
    else $error("empty pipeline refuses input");

  // a new result only comes from stage 3
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_v_q && !$past(m_v_q)) |-> $past(s3_v_q))
    else $error("result without a stage 3 item");

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
// testbench for the can signal extractor: directed and random frames checked against a predictor
`timescale 1ns / 1ps

module tb;
  import csx_pkg::*;

  // signal format codes and their bits
  localparam logic [1:0] FmtIntel          = 2'd0;
  localparam logic [1:0] FmtMotorola       = 2'd1;
  localparam logic [1:0] FmtIntelSigned    = 2'd2;
  localparam logic [1:0] FmtMotorolaSigned = 2'd3;
  localparam int FmtMotoBit = 0;
  localparam int FmtSignBit = 1;

  // product bound, drain time after the last result, watchdog limit, random phase sizes
  localparam longint ProdBound  = 64'sh4000_0000_0000_0000;
  localparam int     DrainCycles = 12;
  localparam int     StallLimit  = 2000;
  localparam int     RandPhases  = 14;
  localparam int     PhaseFrames = 130;

  typedef struct packed {
    logic [IdBits-1:0]    id;
    logic                 ext;
    logic [WordBits-1:0]  payload;
    logic [StampBits-1:0] stamp;
  } frame_t;

  typedef struct packed {
    logic [StampBits-1:0]      stamp;
    logic signed [ValBits-1:0] value;
    logic [MaxLen-1:0]         raw;
  } sig_res_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // frame_id, payload, arrival_time, zero fill
  logic [InDataBits-1:0]  s_axis_tdata = '0;
  // frame_extended
  logic                   s_axis_tuser = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // stamp, physical_value, raw_field
  logic [OutDataBits-1:0] m_axis_tdata;
  logic                   cfg_we_i = 1'b0;
  logic [CfgAddrBits-1:0] cfg_addr_i = '0;
  logic [CfgDataBits-1:0] cfg_wdata_i = '0;

  // register copies, at their reset values
  logic [29:0]               cur_match = '0;
  logic [5:0]                cur_off   = 6'd0;
  logic [5:0]                cur_len   = 6'd8;
  logic [1:0]                cur_fmt   = FmtIntel;
  logic signed [31:0]        cur_slope = 32'sd65536;
  logic signed [ValBits-1:0] cur_icpt  = '0;
  logic signed [ValBits-1:0] cur_lo    = Q48Min;
  logic signed [ValBits-1:0] cur_hi    = Q48Max;
  logic [MaxLen-1:0]         prev_raw  = '0;

  frame_t   frame_q[$];
  sig_res_t sig_exp_q[$];
  frame_t   drv_frame;
  int       send_gap = 0;
  int       recv_stall = 0;
  int       quiet_cycles = 0;
  int       err_cnt = 0;
  bit       no_idle = 1'b0;

  can_signal_extract_scale DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // expected signal value for one frame, updates the stored raw field
  function automatic bit predict_signal(input frame_t f, output sig_res_t r);
    logic [63:0]       swapped, word, mask;
    logic [MaxLen-1:0] raw;
    int unsigned       len, off, top;
    longint            val, prod;
    bit                changed;
    if (f.id != cur_match[IdBits-1:0] || f.ext != cur_match[IdBits]) return 1'b0;
    len = (cur_len > MaxLen) ? MaxLen : cur_len;
    off = cur_off;
    if (len == 0) begin
      raw = '0;
    end else begin
      if (cur_fmt[FmtMotoBit]) begin
        for (int i = 0; i < 8; i++) swapped[8*i +: 8] = f.payload[8*(7-i) +: 8];
        top = off + len;
        // motorola field past the end reads zeros below the payload
        if (top <= WordBits) word = swapped >> (WordBits - top);
        else word = swapped << (top - WordBits);
      end else begin
        word = f.payload >> off;
      end
      mask = (64'd1 << len) - 64'd1;
      word = word & mask;
      raw = word[MaxLen-1:0];
    end
    changed = (raw != prev_raw);
    prev_raw = raw;
    val = longint'(raw);
    if (len != 0 && cur_fmt[FmtSignBit] && raw[len-1]) val = val - (longint'(1) << len);
    prod = val * longint'(cur_slope);
    if (prod > ProdBound) prod = ProdBound;
    if (prod < -ProdBound) prod = -ProdBound;
    prod = prod + longint'(cur_icpt);
    if (prod > longint'(Q48Max)) prod = longint'(Q48Max);
    if (prod < longint'(Q48Min)) prod = longint'(Q48Min);
    // floor first, then ceiling, so crossed limits give the ceiling
    if (prod < longint'(cur_lo)) prod = longint'(cur_lo);
    if (prod > longint'(cur_hi)) prod = longint'(cur_hi);
    if (!changed) return 1'b0;
    r.stamp = f.stamp;
    r.value = prod[ValBits-1:0];
    r.raw   = raw;
    return 1'b1;
  endfunction

  task automatic note_error(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("mismatch: %s", msg);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataBits-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
  endtask

  task automatic apply_setting(input logic [29:0] mid, input logic [5:0] off,
                               input logic [5:0] len, input logic [1:0] fmt,
                               input logic signed [31:0] slp,
                               input logic signed [ValBits-1:0] icp,
                               input logic signed [ValBits-1:0] lo,
                               input logic signed [ValBits-1:0] hi);
    write_reg(REG_MATCH_ID, {18'd0, mid});
    write_reg(REG_BIT_OFFSET, {42'd0, off});
    write_reg(REG_BIT_LENGTH, {42'd0, len});
    write_reg(REG_SIGNAL_FORMAT, {46'd0, fmt});
    write_reg(REG_SLOPE, {16'd0, slp});
    write_reg(REG_INTERCEPT, icp);
    write_reg(REG_LOWER_LIMIT, lo);
    write_reg(REG_UPPER_LIMIT, hi);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_match = mid;
    cur_off   = off;
    cur_len   = len;
    cur_fmt   = fmt;
    cur_slope = slp;
    cur_icpt  = icp;
    cur_lo    = lo;
    cur_hi    = hi;
    @(negedge clk_i);
  endtask

  task automatic push_frame(input logic [IdBits-1:0] id, input logic ext,
                            input logic [63:0] payload, input logic [63:0] stamp);
    frame_t f;
    f.id      = id;
    f.ext     = ext;
    f.payload = payload;
    f.stamp   = stamp;
    frame_q.push_back(f);
  endtask

  // sender stops until the block has delivered everything and gone quiet
  task automatic wait_idle();
    @(negedge clk_i);
    while (frame_q.size() != 0 || s_axis_tvalid || sig_exp_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // frame sender with a random gap after each transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      send_gap      <= 0;
    end else if (s_axis_tvalid && !s_axis_tready) begin
      // hold the frame until its transfer
    end else if (send_gap != 0) begin
      s_axis_tvalid <= 1'b0;
      send_gap      <= send_gap - 1;
    end else if (frame_q.size() != 0) begin
      drv_frame = frame_q.pop_front();
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= {3'd0, drv_frame.stamp, drv_frame.payload, drv_frame.id};
      s_axis_tuser  <= drv_frame.ext;
      send_gap      <= no_idle ? 0 : $urandom_range(0, 7);
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  // prediction on frame transfers, checking and stalls on result transfers
  always @(posedge clk_i or negedge rst_ni) begin : mon
    frame_t   seen;
    sig_res_t want, got, pred;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_stall    = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        seen.id      = s_axis_tdata[IdBits-1:0];
        seen.payload = s_axis_tdata[IdBits +: WordBits];
        seen.stamp   = s_axis_tdata[IdBits+WordBits +: StampBits];
        seen.ext     = s_axis_tuser;
        if (predict_signal(seen, pred)) sig_exp_q.push_back(pred);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.stamp = m_axis_tdata[StampBits-1:0];
        got.value = m_axis_tdata[StampBits +: ValBits];
        got.raw   = m_axis_tdata[StampBits+ValBits +: MaxLen];
        if (sig_exp_q.size() == 0) begin
          note_error($sformatf("unexpected result stamp=%h value=%h raw=%h",
                               got.stamp, got.value, got.raw));
        end else begin
          want = sig_exp_q.pop_front();
          if (got.stamp !== want.stamp || got.value !== want.value || got.raw !== want.raw)
            note_error($sformatf("stamp %h/%h value %h/%h raw %h/%h (expected/actual)",
                                 want.stamp, got.stamp, want.value, got.value,
                                 want.raw, got.raw));
        end
        recv_stall = no_idle ? 0 : $urandom_range(0, 7);
        m_axis_tready <= (recv_stall == 0);
      end else if (recv_stall != 0) begin
        recv_stall = recv_stall - 1;
        m_axis_tready <= (recv_stall == 0);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any transfer or register write
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == StallLimit) begin
      $display("tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus: directed phases, then random settings with random frames
  initial begin
    logic [29:0]               r_match;
    logic [5:0]                r_off, r_len;
    logic [1:0]                r_fmt;
    logic signed [31:0]        r_slope;
    logic signed [ValBits-1:0] r_icpt, r_lo, r_hi, r_tmp;
    logic [63:0]               rnd, prev_payload;
    frame_t                    f;
    int                        sel;
    int                        bit_idx;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset setting: standard id 0, low byte, unchanged and mismatching frames
    push_frame('0, 1'b0, 64'h0, 64'h0);
    push_frame('0, 1'b0, '1, '1);
    push_frame('0, 1'b0, '1, 64'h1);
    push_frame('1, 1'b1, 64'h12, 64'h2);
    push_frame('0, 1'b1, 64'h34, 64'h5);
    push_frame(29'd1, 1'b0, 64'h56, 64'h6);
    push_frame('0, 1'b0, 64'h80, 64'h8000_0000_0000_0000);
    push_frame('0, 1'b0, 64'h0, 64'h7);
    wait_idle();

    // intel field past bit 63, signed, largest slope and intercept
    apply_setting({1'b1, 29'h1FFF_FFFF}, 6'd60, 6'd32, FmtIntelSigned, 32'sh7FFF_FFFF,
                  Q48Max, Q48Min, Q48Max);
    push_frame('1, 1'b1, '1, 64'h10);
    push_frame(29'h1FFF_FFFE, 1'b1, 64'h0, 64'h11);
    push_frame('1, 1'b1, 64'h1000_0000_0000_0000, 64'h12);
    push_frame('1, 1'b1, 64'h0, 64'h13);
    wait_idle();

    // motorola field past bit 63, smallest slope and intercept
    apply_setting({1'b0, 29'h0ABC_DEF1}, 6'd40, 6'd32, FmtMotorola, 32'sh8000_0000,
                  Q48Min, Q48Min, Q48Max);
    push_frame(29'h0ABC_DEF1, 1'b0, '1, 64'h20);
    push_frame(29'h0ABC_DEF1, 1'b0, 64'h0123_4567_89AB_CDEF, 64'h21);
    push_frame(29'h0ABC_DEF1, 1'b0, 64'h0, 64'h22);
    push_frame(29'h0ABC_DEF1, 1'b0, '1, 64'h23);
    wait_idle();

    // empty field with crossed limits
    apply_setting({1'b0, 29'h0ABC_DEF1}, 6'd63, 6'd0, FmtMotorolaSigned, 32'sd65536,
                  48'sd12345 <<< 16, 48'sd1000 <<< 16, -(48'sd5 <<< 16));
    push_frame(29'h0ABC_DEF1, 1'b0, '1, 64'h30);
    push_frame(29'h0ABC_DEF1, 1'b0, 64'h5555_AAAA_5555_AAAA, 64'h31);
    wait_idle();

    // length above 32, negative slope, narrow limits
    apply_setting({1'b1, 29'h0000_0123}, 6'd32, 6'd63, FmtIntelSigned, -32'sd1, '0,
                  -(48'sd1 <<< 20), 48'sd1 <<< 20);
    push_frame(29'h123, 1'b1, 64'h8000_0000_0000_0000, 64'h40);
    push_frame(29'h123, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF, 64'h41);
    push_frame(29'h123, 1'b1, 64'h0000_0001_1234_5678, 64'h42);
    push_frame(29'h123, 1'b1, 64'hFFFF_FFFF_0000_0000, 64'h43);
    wait_idle();

    prev_payload = '0;
    for (int p = 0; p < RandPhases; p++) begin
      no_idle = (p % 4 == 1);
      r_match = 30'($urandom);
      case ($urandom_range(0, 3))
        0: r_off = 6'd0;
        1: r_off = 6'd63;
        default: r_off = 6'($urandom_range(0, 63));
      endcase
      case ($urandom_range(0, 9))
        0: r_len = 6'd0;
        1: r_len = 6'($urandom_range(33, 63));
        2: r_len = 6'd32;
        3: r_len = 6'd1;
        default: r_len = 6'($urandom_range(1, 32));
      endcase
      r_fmt = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 5))
        0: r_slope = 32'sh8000_0000;
        1: r_slope = 32'sh7FFF_FFFF;
        2: r_slope = $urandom;
        default: r_slope = $urandom_range(0, 32'h40000) - 32'h20000;
      endcase
      rnd = {$urandom, $urandom};
      case ($urandom_range(0, 5))
        0: r_icpt = Q48Max;
        1: r_icpt = Q48Min;
        2: r_icpt = rnd[47:0];
        default: r_icpt = $signed(rnd[47:0]) >>> 10;
      endcase
      rnd = {$urandom, $urandom};
      r_lo = rnd[47:0];
      rnd = {$urandom, $urandom};
      r_hi = rnd[47:0];
      case ($urandom_range(0, 3))
        0: begin
          r_lo = Q48Min;
          r_hi = Q48Max;
        end
        1: begin
          if (r_lo > r_hi) begin
            r_tmp = r_lo;
            r_lo  = r_hi;
            r_hi  = r_tmp;
          end
        end
        2: begin
          if (r_lo < r_hi) begin
            r_tmp = r_lo;
            r_lo  = r_hi;
            r_hi  = r_tmp;
          end
        end
        default: begin
          r_lo = 48'(-($signed({1'b0, r_lo[29:0]})));
          r_hi = 48'($signed({1'b0, r_hi[29:0]}));
        end
      endcase
      apply_setting(r_match, r_off, r_len, r_fmt, r_slope, r_icpt, r_lo, r_hi);

      // mostly matching frames, some near misses and some noise
      for (int k = 0; k < PhaseFrames; k++) begin
        sel = $urandom_range(0, 99);
        f.stamp = {$urandom, $urandom};
        if (sel < 25) begin
          f.payload = prev_payload;
        end else begin
          case ($urandom_range(0, 7))
            0: f.payload = '1;
            1: f.payload = '0;
            default: f.payload = {$urandom, $urandom};
          endcase
        end
        f.id  = r_match[IdBits-1:0];
        f.ext = r_match[IdBits];
        if (sel >= 75 && sel < 90) begin
          if ($urandom_range(0, 1)) begin
            f.ext = ~f.ext;
          end else begin
            bit_idx = $urandom_range(0, IdBits-1);
            f.id[bit_idx] = ~f.id[bit_idx];
          end
        end else if (sel >= 90) begin
          f.id  = 29'($urandom);
          f.ext = 1'($urandom);
        end
        prev_payload = f.payload;
        frame_q.push_back(f);
      end
      wait_idle();
    end

    if (err_cnt == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

endmodule
